@@ rtl/core/asp_pkg.sv @@
// Shared constants, types and control codes of the adjacent-swap permutation generator.
package asp_pkg;

   // Longest permutation handled; one cell per position.
   localparam int MAX_LEN = 8;

   // Element values 1..MAX_LEN and the length register are four bits wide.
   localparam int ELEM_W = 4;
   localparam int LEN_W  = 4;

   // Position index into the chain of cells.
   localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // Width used for position and length comparisons; holds MAX_LEN + 1.
   localparam int CMP_W = 5;

   // Scan counter counts 0..MAX_LEN.
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   // Positions that fit in the packed result word.
   localparam int OUT_SLOTS = (MAX_LEN < 8) ? MAX_LEN : 8;
   localparam int DATA_W    = 32;
   localparam int REQ_W     = 8;

   // Update command sent to every cell.
   localparam logic [1:0] KIND_HOLD  = 2'd0;
   localparam logic [1:0] KIND_IDENT = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;

   // Largest mobile element found so far: value zero means none.
   typedef struct packed {
      logic [ELEM_W-1:0] val;
      logic [POS_W-1:0]  pos;
      logic              left;
   } best_type;

   typedef struct packed {
      logic [1:0] kind;
      best_type   best;
   } ctrl_type;

endpackage

@@ rtl/core/asp_cell.sv @@
// One position of the permutation: its element, the element's direction and a scan stage.
module asp_cell import asp_pkg::*; (
   input  logic              clock,
   input  logic [POS_W-1:0]  pos_idx,
   input  logic [LEN_W-1:0]  len,
   input  ctrl_type          ctrl,
   input  logic [ELEM_W-1:0] left_val,
   input  logic              left_dir,
   input  logic [ELEM_W-1:0] right_val,
   input  logic              right_dir,
   input  best_type          scan_in,
   output best_type          scan_out,
   output logic [ELEM_W-1:0] val,
   output logic              dir
);

   logic [ELEM_W-1:0] val_ff, val_in;
   logic              dir_ff, dir_in;
   best_type          scan_ff, scan_in_next;

   logic [CMP_W-1:0]  p_ext, q_ext;
   logic              has_left, has_right, mobile;
   logic              at_q, take_left, take_right;
   logic [ELEM_W-1:0] moved_val;
   logic              moved_dir;

   assign p_ext = CMP_W'(pos_idx);
   assign q_ext = CMP_W'(ctrl.best.pos);

   // An element is mobile when the neighbour it points at exists and is smaller.
   assign has_left  = (pos_idx != '0);
   assign has_right = ((p_ext + CMP_W'(1)) < CMP_W'(len));
   assign mobile    = dir_ff ? (has_left && (left_val < val_ff))
                             : (has_right && (right_val < val_ff));

   always_comb begin
      scan_in_next = scan_in;
      if (mobile && (val_ff > scan_in.val)) begin
         scan_in_next.val  = val_ff;
         scan_in_next.pos  = pos_idx;
         scan_in_next.left = dir_ff;
      end
   end

   // The swap involves the moving element's cell and the one it points at.
   assign at_q       = (p_ext == q_ext);
   assign take_left  = (at_q && ctrl.best.left) ||
                       ((p_ext == q_ext + CMP_W'(1)) && !ctrl.best.left);
   assign take_right = (at_q && !ctrl.best.left) ||
                       ((p_ext + CMP_W'(1) == q_ext) && ctrl.best.left);

   always_comb begin
      moved_val = val_ff;
      moved_dir = dir_ff;
      if (take_left) begin
         moved_val = left_val;
         moved_dir = left_dir;
      end else if (take_right) begin
         moved_val = right_val;
         moved_dir = right_dir;
      end
   end

   always_comb begin
      val_in = val_ff;
      dir_in = dir_ff;
      case (ctrl.kind)
         KIND_IDENT: begin
            val_in = (p_ext < CMP_W'(len)) ? (ELEM_W'(pos_idx) + ELEM_W'(1)) : '0;
            dir_in = 1'b1;
         end
         KIND_STEP: begin
            // Elements larger than the one moved reverse their direction.
            val_in = moved_val;
            dir_in = moved_dir ^ (moved_val > ctrl.best.val);
         end
         default: begin
            val_in = val_ff;
            dir_in = dir_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      dir_ff  <= dir_in;
      scan_ff <= scan_in_next;
   end

   assign val      = val_ff;
   assign dir      = dir_ff;
   assign scan_out = scan_ff;

endmodule

@@ rtl/core/adjacent_swap_permutation_generator.sv @@
// Top level of the adjacent-swap (plain changes) permutation generator.
//
// Each request transfer yields one permutation of 1..n in Steinhaus-Johnson-Trotter
// order, so that successive permutations differ by a single adjacent swap. The
// permutation lives in a row of MAX_LEN cells, one per position, each holding its
// element and that element's direction. After a request is accepted, the update
// state swaps and flips directions in every cell at once; then, in the scan state,
// the search for the largest mobile element ripples cell by cell down the registered
// scan chain, the done state loads the result register, and the block returns to
// idle, where alone it accepts the next request. The result of that scan gives the
// final-permutation flag and is kept as the move for the next request. A result
// that has not yet been taken does not stop the next request from being accepted;
// it only holds the block before its own result load. The first request after
// reset or after a length write, and any request with restart set, gives the
// identity; the request after the final permutation wraps to the identity as well.
// A length of zero acts as one and a length above MAX_LEN acts as MAX_LEN.
// Configuration must be written only while the block is idle, which it does not enforce.
module adjacent_swap_permutation_generator import asp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // Request channel.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // bit 0: restart; bits 7..1: zero
   // Result channel.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // bits 31..0: perm_packed
   output logic              rsp_tlast,   // last_in_sequence
   // Length register.
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam logic [LEN_W-1:0] LEN_RESET =
      LEN_W'((MAX_LEN < 8) ? MAX_LEN : 8);

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ident_given_ff, ident_given_in;
   logic              restart_ff, restart_in;
   best_type          best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   ctrl_type          ctrl;
   logic              req_fire, rsp_load;
   logic [ELEM_W-1:0] val_w  [MAX_LEN];
   logic              dir_w  [MAX_LEN];
   best_type          scan_w [MAX_LEN];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // The result register is loaded once the scan is done and the register is free.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // The update cycle either restarts at the identity or makes the move that the
   // previous scan found; no mobile element means the cycle is complete and wraps.
   always_comb begin
      ctrl.kind = KIND_HOLD;
      ctrl.best = best_ff;
      if (state_ff == ST_UPDATE) begin
         if (restart_ff || !ident_given_ff || (best_ff.val == '0)) begin
            ctrl.kind = KIND_IDENT;
         end else begin
            ctrl.kind = KIND_STEP;
         end
      end
   end

   // The row of cells; each hands its element to both neighbours for the swap
   // and its best-so-far to the next cell for the scan.
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic [ELEM_W-1:0] lv, rv;
      logic              ld, rd;
      best_type          sin;

      if (i == 0) begin : g_first
         assign lv  = '0;
         assign ld  = 1'b0;
         assign sin = '0;
      end else begin : g_inner
         assign lv  = val_w[i-1];
         assign ld  = dir_w[i-1];
         assign sin = scan_w[i-1];
      end

      if (i == MAX_LEN - 1) begin : g_last
         assign rv = '0;
         assign rd = 1'b0;
      end else begin : g_body
         assign rv = val_w[i+1];
         assign rd = dir_w[i+1];
      end

      asp_cell u_cell (
         .clock     (clock),
         .pos_idx   (POS_W'(i)),
         .len       (len_ff),
         .ctrl      (ctrl),
         .left_val  (lv),
         .left_dir  (ld),
         .right_val (rv),
         .right_dir (rd),
         .scan_in   (sin),
         .scan_out  (scan_w[i]),
         .val       (val_w[i]),
         .dir       (dir_w[i])
      );
   end

   // Pack the positions that fit; the cells beyond the length already hold zero.
   always_comb begin
      rsp_data_in = '0;
      for (int p = 0; p < OUT_SLOTS; p++) begin
         rsp_data_in[ELEM_W*p +: ELEM_W] = val_w[p];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      best_in        = best_ff;
      restart_in     = restart_ff;
      ident_given_in = ident_given_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               restart_in = req_tdata[0];
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ident_given_in = 1'b1;
            cnt_in         = '0;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            // The last cell's stage has settled once the counter reaches MAX_LEN.
            if (cnt_ff == CNT_W'(MAX_LEN)) begin
               best_in  = scan_w[MAX_LEN-1];
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A length write restarts the sequence at the identity.
      if (csr_wr_en) begin
         ident_given_in = 1'b0;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            len_in = LEN_W'(1);
         end else if (csr_wr_data > LEN_W'(MAX_LEN)) begin
            len_in = LEN_W'(MAX_LEN);
         end else begin
            len_in = csr_wr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (best_ff.val == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         len_ff         <= LEN_RESET;
         ident_given_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         len_ff         <= len_in;
         ident_given_ff <= ident_given_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      restart_ff  <= restart_in;
      rsp_last_ff <= rsp_last_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_UPDATE))
      else $error("accepted request did not start an update");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) && (len_ff <= LEN_W'(MAX_LEN)))
      else $error("length register out of range");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded outside the done state");

   a_scan_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(MAX_LEN)))
      else $error("scan counter overran the chain");

   a_update_marks_identity: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && !csr_wr_en) |=> ident_given_ff)
      else $error("identity flag not set after an update");
`endif

endmodule
